// ----- rtl/core/pps_pkg.sv -----
// shared types, constants and divider step function for the sprite projection block
package pps_pkg;

    localparam int COEFF_BITS_DEFAULT = 21;
    localparam int ROW_BITS           = 63;
    localparam int CAM_BITS           = 48;
    localparam int DIV_STEPS          = 25;
    localparam int CFG_ADDR_BITS      = 5;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ROW_DEPTH = 2'd0;
    localparam logic [1:0] REG_ROW_HORZ  = 2'd1;
    localparam logic [1:0] REG_ROW_VERT  = 2'd2;
    localparam logic [1:0] REG_CAMERA    = 2'd3;

    localparam logic [DIV_STEPS-1:0] SCALE_NUMERATOR = 25'h010_0000;
    localparam logic [15:0]          SCREEN_X_OFFSET = 16'd160;
    localparam logic [15:0]          SCREEN_Y_OFFSET = 16'd100;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] src_w;
        logic [15:0] src_h;
        logic [15:0] ext_w;
        logic [15:0] ext_h;
    } side_t;

    typedef struct packed {
        logic [15:0]          rem;
        logic [DIV_STEPS-1:0] num;
    } lane_t;

    typedef struct packed {
        side_t       side;
        logic [15:0] depth;
        logic        neg_x;
        logic        neg_y;
        lane_t       lane_s;
        lane_t       lane_x;
        lane_t       lane_y;
    } div_item_t;

    // one restoring division step: next dividend bit into the remainder,
    // quotient bit into the bottom of the dividend word
    function automatic lane_t div_step(lane_t in_lane, logic [15:0] divisor);
        logic [16:0] trial;
        logic [16:0] diff;
        lane_t       res;
        trial = {in_lane.rem, in_lane.num[DIV_STEPS-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            res.rem = diff[15:0];
            res.num = {in_lane.num[DIV_STEPS-2:0], 1'b1};
        end else begin
            res.rem = trial[15:0];
            res.num = {in_lane.num[DIV_STEPS-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/pps_front.sv -----
// front pipeline: camera offset, row products, row sums and depth check
module pps_front #(
    parameter int COEFF_BITS = pps_pkg::COEFF_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pps_pkg::ROW_BITS-1:0]  row_depth,
    input  logic [pps_pkg::ROW_BITS-1:0]  row_horz,
    input  logic [pps_pkg::ROW_BITS-1:0]  row_vert,
    input  logic [pps_pkg::CAM_BITS-1:0]  camera,
    input  logic                          in_valid,
    input  logic                          in_active,
    input  logic [47:0]                   in_point,
    input  pps_pkg::side_t                in_side,
    output logic                          in_ready,
    output logic                          out_valid,
    output pps_pkg::div_item_t            out_item,
    input  logic                          out_ready
);

    localparam int PW = 16 + COEFF_BITS;

    logic               a_valid_reg, b_valid_reg, c_valid_reg;
    logic               en_a, en_b, en_c;
    logic signed [15:0] p_reg [3];
    pps_pkg::side_t     side_a_reg, side_b_reg;
    logic [31:0]        prod_reg [3][3];
    logic [31:0]        prod_next [3][3];
    logic [31:0]        sum_d, sum_h, sum_v;
    pps_pkg::div_item_t item_reg, item_next;

    // per-stage ready chain so bubbles collapse
    assign en_c     = !c_valid_reg || out_ready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    // stage a: subtract camera with 16-bit wrap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en_a) begin
            a_valid_reg <= in_valid && in_active;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            for (int k = 0; k < 3; k++) begin
                p_reg[k] <= in_point[16*k +: 16] - camera[16*k +: 16];
            end
            side_a_reg <= in_side;
        end
    end

    // stage b: nine coefficient products, low 32 bits kept
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar k = 0; k < 3; k++) begin : g_col
            logic [pps_pkg::ROW_BITS-1:0] row;
            logic signed [COEFF_BITS-1:0] coef;
            logic signed [PW-1:0]         prod;
            assign row  = (r == 0) ? row_depth : ((r == 1) ? row_horz : row_vert);
            assign coef = row[k*COEFF_BITS +: COEFF_BITS];
            assign prod = PW'(p_reg[k]) * PW'(coef);
            assign prod_next[r][k] = prod[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            prod_reg   <= prod_next;
            side_b_reg <= side_a_reg;
        end
    end

    // stage c: row sums, depth adjust and divider setup
    assign sum_d = prod_reg[0][0] + prod_reg[0][1] + prod_reg[0][2];
    assign sum_h = prod_reg[1][0] + prod_reg[1][1] + prod_reg[1][2];
    assign sum_v = prod_reg[2][0] + prod_reg[2][1] + prod_reg[2][2];

    always_comb begin
        item_next.side       = side_b_reg;
        // negative depth plus 0x10000 equals its low 16 bits
        item_next.depth      = sum_d[30:15];
        item_next.neg_x      = sum_h[31];
        item_next.neg_y      = sum_v[31];
        item_next.lane_s.rem = 16'd0;
        item_next.lane_s.num = pps_pkg::SCALE_NUMERATOR;
        item_next.lane_x.rem = 16'd0;
        item_next.lane_x.num = sum_h[31] ? (25'd0 - sum_h[31:7]) : sum_h[31:7];
        item_next.lane_y.rem = 16'd0;
        item_next.lane_y.num = sum_v[31] ? (25'd0 - sum_v[31:7]) : sum_v[31:7];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en_c) begin
            c_valid_reg <= b_valid_reg && (sum_d[30:15] != 16'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- rtl/core/pps_div_cell.sv -----
// one divider cell: a quotient bit for the scale, x and y lanes
module pps_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  pps_pkg::div_item_t in_item,
    output logic               in_ready,
    output logic               out_valid,
    output pps_pkg::div_item_t out_item,
    input  logic               out_ready
);

    logic               valid_reg;
    pps_pkg::div_item_t item_reg, item_next;

    assign in_ready = !valid_reg || out_ready;

    // step all three lanes against the shared divisor
    always_comb begin
        item_next        = in_item;
        item_next.lane_s = pps_pkg::div_step(in_item.lane_s, in_item.depth);
        item_next.lane_x = pps_pkg::div_step(in_item.lane_x, in_item.depth);
        item_next.lane_y = pps_pkg::div_step(in_item.lane_y, in_item.depth);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- rtl/core/pps_back.sv -----
// result stage: signs, screen offsets, centering, sprite scaling, output register
module pps_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  pps_pkg::div_item_t in_item,
    output logic               in_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [103:0]       m_tdata
);

    logic        valid_reg;
    logic [103:0] data_reg, data_next;
    logic [15:0] scale, qx, qy, sx, sy;
    logic [31:0] pw, ph;

    assign in_ready = !valid_reg || m_tready;

    // quotient signs, offsets and scaled sizes
    always_comb begin
        scale = in_item.lane_s.num[15:0];
        qx    = in_item.neg_x ? (16'd0 - in_item.lane_x.num[15:0]) : in_item.lane_x.num[15:0];
        qy    = in_item.neg_y ? (16'd0 - in_item.lane_y.num[15:0]) : in_item.lane_y.num[15:0];
        sx    = qx + pps_pkg::SCREEN_X_OFFSET;
        sy    = qy + pps_pkg::SCREEN_Y_OFFSET;
        pw    = 32'(in_item.side.src_w) * 32'(scale);
        ph    = 32'(in_item.side.src_h) * 32'(scale);
        data_next = {scale,
                     in_item.depth,
                     sy - {1'b0, in_item.side.ext_h[15:1]},
                     sx - {1'b0, in_item.side.ext_w[15:1]},
                     ph[25:10],
                     pw[25:10],
                     in_item.side.tag};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ----- rtl/core/perspective_project_sprite.sv -----
// top level of the sprite perspective projection block
//
//  channel   direction  handshake            contents
//  s_*       in         s_tvalid/s_tready    world point, sprite sizes, tag; tuser active
//  m_*       out        m_tvalid/m_tready    tag, scaled size, draw position, depth, scale
//  apb       in/out     psel/penable/pready  matrix rows and camera position
//
// one item per cycle while m_tready holds; three front stages, 25 divider
// cells (one quotient bit each, 25-bit dividends), one output register
// inactive items and items of zero depth leave no result
// reset is synchronous and clears all valid flags and the configuration registers
// each stage stalls only when it holds an item that cannot move on
module perspective_project_sprite #(
    parameter int COEFF_BITS = pps_pkg::COEFF_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // x, y, z, source_width, source_height, box_w, box_h, tag
    input  logic [119:0]                      s_tdata,
    // object_active
    input  logic [0:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tag, size_w, size_h, draw_x, draw_y, depth_out, inv_depth
    output logic [103:0]                      m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pps_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [63:0]                       pwdata,
    output logic [63:0]                       prdata,
    output logic                              pready
);

    localparam int N = pps_pkg::DIV_STEPS;

    logic [pps_pkg::ROW_BITS-1:0] row_depth_reg, row_horz_reg, row_vert_reg;
    logic [pps_pkg::CAM_BITS-1:0] camera_reg;
    pps_pkg::side_t               in_side;
    logic                         chain_valid [N+1];
    logic                         chain_ready [N+1];
    pps_pkg::div_item_t           chain_item  [N+1];

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_depth_reg <= '0;
            row_horz_reg  <= '0;
            row_vert_reg  <= '0;
            camera_reg    <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:3])
                pps_pkg::REG_ROW_DEPTH: row_depth_reg <= pwdata[62:0];
                pps_pkg::REG_ROW_HORZ:  row_horz_reg  <= pwdata[62:0];
                pps_pkg::REG_ROW_VERT:  row_vert_reg  <= pwdata[62:0];
                pps_pkg::REG_CAMERA:    camera_reg    <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            pps_pkg::REG_ROW_DEPTH: prdata = {1'b0, row_depth_reg};
            pps_pkg::REG_ROW_HORZ:  prdata = {1'b0, row_horz_reg};
            pps_pkg::REG_ROW_VERT:  prdata = {1'b0, row_vert_reg};
            pps_pkg::REG_CAMERA:    prdata = {16'd0, camera_reg};
            default:                prdata = '0;
        endcase
    end

    // input unpacking
    assign in_side.src_w = s_tdata[63:48];
    assign in_side.src_h = s_tdata[79:64];
    assign in_side.ext_w = s_tdata[95:80];
    assign in_side.ext_h = s_tdata[111:96];
    assign in_side.tag   = s_tdata[119:112];

    pps_front #(
        .COEFF_BITS(COEFF_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .row_depth (row_depth_reg),
        .row_horz  (row_horz_reg),
        .row_vert  (row_vert_reg),
        .camera    (camera_reg),
        .in_valid  (s_tvalid),
        .in_active (s_tuser[0]),
        .in_point  (s_tdata[47:0]),
        .in_side   (in_side),
        .in_ready  (s_tready),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0]),
        .out_ready (chain_ready[0])
    );

    // divider cell chain
    for (genvar i = 0; i < N; i++) begin : g_cell
        pps_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .in_ready  (chain_ready[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1]),
            .out_ready (chain_ready[i+1])
        );
    end

    pps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_valid[N]),
        .in_item  (chain_item[N]),
        .in_ready (chain_ready[N]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/core/pps_checker.sv -----
// port-level checks for the sprite projection block, bound to the top level
module pps_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic [103:0] m_tdata,
    input logic         m_tvalid,
    input logic         m_tready
);

    // output is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // zero depth never reaches the output
    a_depth_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[87:72] != 16'd0)
        else $error("result with zero depth");

    // unit depth wraps the scale to zero and so the sizes too
    a_unit_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[87:72] == 16'd1 |->
        m_tdata[103:88] == 16'd0 && m_tdata[39:8] == 32'd0)
        else $error("unit depth scale not zero");

endmodule

bind perspective_project_sprite pps_checker u_pps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
